FILE: design/lsh_pkg.sv
// lsh_pkg: shared constants and types for the three-channel laplacian sharpen block
// no dependencies
`default_nettype none

package lsh_pkg;

  localparam int MAX_LINE = 1024;
  localparam int COL_W    = $clog2(MAX_LINE);
  localparam int FILL_W   = COL_W + 1;
  localparam int PIX_W    = 24;

  localparam logic [11:0] BYPASS_LIMIT = 12'd26;
  localparam logic [10:0] MIN_WIDTH    = 11'd3;
  localparam logic [10:0] MAX_WIDTH    = 11'd1024;

  localparam logic [11:0] STRENGTH_RESET = 12'd256;
  localparam logic [10:0] WIDTH_RESET    = 11'd1024;

  typedef enum logic {
    REG_STRENGTH = 1'b0,
    REG_WIDTH    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] y;
  } pix_t;

endpackage

`default_nettype wire

FILE: design/laplacian_sharpen_3ch.sv
// laplacian_sharpen_3ch: 3x3 window, a two-row line store and 5-point sharpen over y/u/v words
// depends on lsh_pkg
//
//   channel   handshake                   word
//   pix       pix_valid / pix_ready       first_of_frame, luma_in, cb_in, cr_in
//   res       res_valid / res_ready       luma_out, cb_out, cr_out, row_end
//   cfg       cfg_we                      cfg_index, cfg_data
//
// one word per clock sustained while the output is not stalled; registered steps in order:
// line store read, window, multiply, clamp into the output register
// line stores need no clearing pass: entries past the highest column written since
// reset read as zero
// reset clears counters and stage valids; a stalled output holds the pipeline, and
// empty stages still take words
`default_nettype none

module laplacian_sharpen_3ch (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire logic        first_of_frame,
  input  wire logic [7:0]  luma_in,
  input  wire logic [7:0]  cb_in,
  input  wire logic [7:0]  cr_in,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [7:0]       luma_out,
  output logic [7:0]       cb_out,
  output logic [7:0]       cr_out,
  output logic             row_end,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int COL_W  = lsh_pkg::COL_W;
  localparam int FILL_W = lsh_pkg::FILL_W;

  // configuration
  logic [11:0] strength;
  logic [10:0] line_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength   <= lsh_pkg::STRENGTH_RESET;
      line_width <= lsh_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (lsh_pkg::reg_index_t'(cfg_index))
        lsh_pkg::REG_STRENGTH: strength   <= cfg_data;
        lsh_pkg::REG_WIDTH:    line_width <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic s1_valid, s2_valid, s3_valid;
  logic out_free, s3_free, s2_free, s1_free;
  logic accept, s1_adv, s2_adv;

  assign out_free  = !res_valid || res_ready;
  assign s3_free   = !s3_valid || out_free;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign pix_ready = s1_free;
  assign accept    = pix_valid && s1_free;
  assign s1_adv    = s1_valid && s2_free;
  assign s2_adv    = s2_valid && s3_free;

  // position counters
  logic [COL_W-1:0]  col_cnt, col0;
  logic [1:0]        row_cnt, row0;
  logic [FILL_W-1:0] fill;
  logic [10:0]       w_eff;
  logic              last0, pos0;
  lsh_pkg::pix_t     px0;

  always_comb begin
    if (line_width < lsh_pkg::MIN_WIDTH) begin
      w_eff = lsh_pkg::MIN_WIDTH;
    end else if (line_width > lsh_pkg::MAX_WIDTH) begin
      w_eff = lsh_pkg::MAX_WIDTH;
    end else begin
      w_eff = line_width;
    end
    col0  = first_of_frame ? '0 : col_cnt;
    row0  = first_of_frame ? 2'd0 : row_cnt;
    last0 = ({1'b0, col0} + 11'd1) >= w_eff;
    pos0  = (col0 >= COL_W'(2)) && (row0 == 2'd2);
    px0   = '{cr: cr_in, cb: cb_in, y: luma_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= 2'd0;
      fill    <= '0;
    end else if (accept) begin
      if (last0) begin
        col_cnt <= '0;
        row_cnt <= (row0 == 2'd2) ? 2'd2 : row0 + 2'd1;
      end else begin
        col_cnt <= col0 + COL_W'(1);
        row_cnt <= row0;
      end
      if ({1'b0, col0} == fill) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // line stores: one entry holds {two rows up, one row up}
  logic [2*lsh_pkg::PIX_W-1:0] line_mem [lsh_pkg::MAX_LINE];
  logic [2*lsh_pkg::PIX_W-1:0] rd_q, fwd_q;
  logic [COL_W-1:0]            s1_col;
  lsh_pkg::pix_t               s1_px, s1_top, s1_mid;
  logic                        s1_last, s1_pos, s1_zero, s1_fwd;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col0];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= {s1_mid, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pix_valid;
    end
    if (accept) begin
      s1_px   <= px0;
      s1_col  <= col0;
      s1_last <= last0;
      s1_pos  <= pos0;
      s1_zero <= {1'b0, col0} >= fill;
      s1_fwd  <= s1_valid && (s1_col == col0);
      fwd_q   <= {s1_mid, s1_px};
    end
  end

  always_comb begin
    priority if (s1_fwd) begin
      {s1_top, s1_mid} = fwd_q;
    end else if (s1_zero) begin
      {s1_top, s1_mid} = '0;
    end else begin
      {s1_top, s1_mid} = rd_q;
    end
  end

  // 3x3 window, corners dropped
  lsh_pkg::pix_t t1, t2, m0, m1, m2, b1, b2;
  logic          s2_last, s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s1_adv) begin
      t1      <= t2;
      t2      <= s1_top;
      m0      <= m1;
      m1      <= m2;
      m2      <= s1_mid;
      b1      <= b2;
      b2      <= s1_px;
      s2_last <= s1_last;
      s2_pos  <= s1_pos;
    end
  end

  // laplacian times strength
  logic                bypass, emit;
  logic [7:0]          c2 [3];
  logic signed [23:0]  p2 [3];
  logic signed [10:0]  d2 [3];
  logic signed [12:0]  s_signed;

  always_comb begin
    bypass   = strength < lsh_pkg::BYPASS_LIMIT;
    emit     = bypass || s2_pos;
    s_signed = $signed({1'b0, strength});
    for (int k = 0; k < 3; k++) begin
      d2[k] = $signed({1'b0, m1[8*k +: 8], 2'b00})
            - $signed({3'b000, t1[8*k +: 8]}) - $signed({3'b000, b1[8*k +: 8]})
            - $signed({3'b000, m0[8*k +: 8]}) - $signed({3'b000, m2[8*k +: 8]});
      if (bypass) begin
        c2[k] = b2[8*k +: 8];
        p2[k] = '0;
      end else begin
        c2[k] = m1[8*k +: 8];
        p2[k] = s_signed * d2[k];
      end
    end
  end

  logic [7:0]         s3_c [3];
  logic signed [23:0] s3_p [3];
  logic               s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid && emit;
    end
    if (s2_adv) begin
      s3_c    <= c2;
      s3_p    <= p2;
      s3_last <= s2_last;
    end
  end

  // floor, add centre (newest pixel in bypass), clamp
  logic signed [16:0] v3 [3];
  logic [7:0]         o3 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v3[k] = $signed({9'd0, s3_c[k]}) + 17'($signed(s3_p[k][23:8]));
      if (v3[k] < 0) begin
        o3[k] = 8'd0;
      end else if (v3[k] > 17'sd255) begin
        o3[k] = 8'd255;
      end else begin
        o3[k] = v3[k][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s3_valid;
    end
    if (s3_valid && out_free) begin
      luma_out <= o3[0];
      cb_out   <= o3[1];
      cr_out   <= o3[2];
      row_end  <= s3_last;
    end
  end

endmodule

`default_nettype wire

FILE: design/lsh_checker.sv
// lsh_checker: port-level checks for laplacian_sharpen_3ch, bound to the top level
// depends on laplacian_sharpen_3ch ports only
`default_nettype none

module lsh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pix_valid,
  input wire logic        pix_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [7:0]  luma_out,
  input wire logic [7:0]  cb_out,
  input wire logic [7:0]  cr_out,
  input wire logic        row_end
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(luma_out) && $stable(cb_out)
      && $stable(cr_out) && $stable(row_end))
    else $error("stalled result word changed");

  // a free output means every stage can move
  a_ready_when_free: assert property (@(posedge clk)
    (!res_valid || res_ready) |-> pix_ready)
    else $error("input stalled while output free");

  // pipeline depth after reset
  a_reset_latency: assert property (@(posedge clk)
    rst |=> !res_valid ##1 !res_valid ##1 !res_valid)
    else $error("result appeared too soon after reset");

endmodule

bind laplacian_sharpen_3ch lsh_checker u_lsh_checker (.*);

`default_nettype wire
